FILE: rtl/clock_tempo_tracker_defines.svh
// Assertion helpers for the checker file.
// Every property is clocked on clk and held off while arst_n is low.
`ifndef CLOCK_TEMPO_TRACKER_DEFINES_SVH
`define CLOCK_TEMPO_TRACKER_DEFINES_SVH

// Condition that must hold at every edge
`define CTT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication
`define CTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ctt_pkg.sv
package ctt_pkg;

	// Input beat: one audio sample
	typedef struct packed {
		logic signed [14:0] clock_level;
		logic               clock_connected;
		logic [12:0]        knob_tempo;
	} in_t;

	// Output beat: one result per sample
	typedef struct packed {
		logic        step_edge;
		logic        quarter_edge;
		logic        external_mode;
		logic [12:0] tempo_now;
	} out_t;

	// Register indexes
	typedef enum logic [0:0] {
		CFG_SAMPLE_RATE     = 1'b0,
		CFG_PULSES_PER_STEP = 1'b1
	} cfg_index_t;

	localparam int SR_W = 18;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic start;
		logic sel_mod;
		logic mod_take;
		logic adj;
		logic finish;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_mod;
		logic div_done;
		logic out_free;
	} status_t;

	// Tempo in 1/16 BPM
	localparam logic [12:0] TEMPO_MIN   = 13'd320;
	localparam logic [12:0] TEMPO_MAX   = 13'd4800;
	localparam logic [12:0] TEMPO_RESET = 13'd1920;

	// Schmitt thresholds in mV
	localparam logic signed [14:0] TRIG_LOW_MV  = 15'sd100;
	localparam logic signed [14:0] TRIG_HIGH_MV = 15'sd2000;

	localparam logic [SR_W-1:0] SR_RESET  = 18'd48000;
	localparam logic [7:0]      PPS_RESET = 8'd24;

	// 240 BPM-seconds per step numerator; 3840 = 240 * 16
	localparam logic [7:0]  STEP_NUM_INT = 8'd240;
	localparam logic [11:0] STEP_NUM_EXT = 12'd3840;

	// Interval window: 1 ms .. 10 s
	localparam logic [9:0] MS_PER_S       = 10'd1000;
	localparam logic [3:0] MAX_INTERVAL_S = 4'd10;

	function automatic logic [12:0] clamp_knob(input logic [12:0] k);
		logic [12:0] r;
		if (k < TEMPO_MIN) r = TEMPO_MIN;
		else if (k > TEMPO_MAX) r = TEMPO_MAX;
		else r = k;
		return r;
	endfunction

endpackage

FILE: rtl/clock_tempo_tracker.sv
// Clock divider and tempo tracker, one audio sample per beat. With the clock cable
// connected, a Schmitt trigger (low at 100 mV, high at 2 V) finds clock edges, every
// pulses_per_step-th edge is a sixteenth step, and the sample count between steps sets
// the tempo (clamped to 20..300 BPM, output in 1/16 BPM); otherwise a phase accumulator
// steps at the knob tempo. The shared restoring divider yields one quotient bit per cycle
// and sets the timing, with NW = max(26 + PHASE_FRACTION_BITS, 30). When the output
// register is free, a result is presented once the division for its input beat is done,
// and the next beat can be taken as soon as the sequencer is back in idle. When
// pulses_per_step has been lowered to or below the running pulse count, the next
// clock edge first takes a remainder pass through the same divider.
// Inputs are taken only between samples; a finished result waits in the output register
// while the next sample is accepted. Write sample_rate and pulses_per_step only while no
// sample is in flight.
module clock_tempo_tracker import ctt_pkg::*; #(
	parameter int COUNT_WIDTH         = 24,
	parameter int PHASE_FRACTION_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  cfg_index_t      cfg_index,
	input  logic [SR_W-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  in_t             in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output out_t            out_data
);
	cmd_t    cmd;
	status_t status;

	ctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ctt_dpath #(.CW(COUNT_WIDTH), .F(PHASE_FRACTION_BITS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/ctt_div.sv
// Restoring divider, one quotient bit per cycle
module ctt_div import ctt_pkg::*; #(
	parameter int NW = 34,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CNTW = $clog2(NW + 1);

	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_nxt;

	// Shift in the next numerator bit and try a subtract
	always_comb begin
		trial   = {rem_q, quo_q[NW-1]};
		ge      = trial >= {1'b0, den_q};
		diff    = trial - {1'b0, den_q};
		rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(NW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/ctt_dpath.sv
// Tracker state, config registers, operand setup and output register
module ctt_dpath import ctt_pkg::*; #(
	parameter int CW = 24,
	parameter int F  = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  cfg_index_t      cfg_index,
	input  logic [SR_W-1:0] cfg_data,
	input  in_t             in_data,
	input  cmd_t            cmd,
	output status_t         status,
	input  logic            out_stall,
	output logic            out_valid,
	output out_t            out_data
);
	// Divider sizing: numerator covers 240*rate<<F and 3840*rate
	localparam int NW = (26 + F > 30) ? 26 + F : 30;
	localparam int DW = CW;
	localparam int QW = (NW > 33) ? NW : 33;
	localparam int PW = CW + 10;
	localparam logic [QW-1:0] PERIOD_LIM = (QW'(1) << 32) - (QW'(1) << F);
	localparam logic [32:0]   PH_UNIT    = 33'(1) << F;

	// Config
	logic [SR_W-1:0] sr_q;
	logic [7:0]      pps_q;

	// Tracker state
	logic          trig_q;
	logic [12:0]   tempo_q;
	logic          measured_q;
	logic          follow_q;
	logic [7:0]    pcount_q;
	logic [1:0]    group_q;
	logic [CW-1:0] samples_q;
	logic [31:0]   phase_q;
	logic          out_valid_q;

	// Per-sample work registers
	logic signed [14:0] level_q;
	logic               conn_q;
	logic [12:0]        knob_q;
	logic               upd_q;
	logic               step_q;
	logic               quarter_q;
	logic [8:0]         mod_num_q;
	logic [7:0]         mod_den_q;
	logic [NW-1:0]      div_num_q;
	logic [DW-1:0]      div_den_q;
	logic [32:0]        ph_inc_q;
	logic [12:0]        tcand_q;
	logic [31:0]        period_q;
	out_t               out_q;

	// Divider
	logic          div_done;
	logic [NW-1:0] div_quo;
	logic [DW-1:0] div_rem;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;

	assign div_num = cmd.sel_mod ? NW'(mod_num_q) : div_num_q;
	assign div_den = cmd.sel_mod ? DW'(mod_den_q) : div_den_q;

	ctt_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Sample decode
	logic [12:0]   knob_cl;
	logic          edge_det;
	logic          trig_nxt;
	logic [7:0]    div8;
	logic [8:0]    p1;
	logic          ext_step;
	logic          need_mod;
	logic [CW-1:0] cnt_inc;
	logic [PW-1:0] cnt_ms;
	logic [PW-1:0] sr_max;
	logic          in_window;
	logic [NW-1:0] num_ext;
	logic [NW-1:0] num_int;

	always_comb begin
		knob_cl  = clamp_knob(knob_q);
		edge_det = 1'b0;
		trig_nxt = trig_q;
		if (trig_q) begin
			if (level_q <= TRIG_LOW_MV) trig_nxt = 1'b0;
		end else if (level_q >= TRIG_HIGH_MV) begin
			trig_nxt = 1'b1;
			edge_det = 1'b1;
		end
		div8     = (pps_q == 8'd0) ? 8'd1 : pps_q;
		p1       = {1'b0, pcount_q} + 9'd1;
		ext_step = edge_det && (pcount_q == 8'd0);
		need_mod = conn_q && edge_det && (p1 > {1'b0, div8});
		cnt_inc  = (samples_q == {CW{1'b1}}) ? samples_q : samples_q + CW'(1);
		// Interval window check
		cnt_ms    = PW'(cnt_inc) * PW'(MS_PER_S);
		sr_max    = PW'(sr_q) * PW'(MAX_INTERVAL_S);
		in_window = (cnt_ms > PW'(sr_q)) && (PW'(cnt_inc) < sr_max);
		num_ext   = NW'(sr_q) * NW'(STEP_NUM_EXT);
		num_int   = (NW'(sr_q) * NW'(STEP_NUM_INT)) << F;
	end

	// Internal phase step
	logic [32:0] ph_sub;
	logic        ph_ge;
	logic        ph_ge2;
	logic [31:0] ph_next;
	logic        int_step;

	always_comb begin
		ph_ge    = ph_inc_q >= {1'b0, period_q};
		ph_sub   = ph_inc_q - {1'b0, period_q};
		ph_ge2   = ph_sub >= {1'b0, period_q};
		int_step = ph_ge;
		if (!ph_ge) ph_next = ph_inc_q[31:0];
		else if (ph_ge2) ph_next = '0;
		else ph_next = ph_sub[31:0];
	end

	// Quotient limits
	logic [QW-1:0] quo_x;
	logic [12:0]   tcand;
	logic [31:0]   period;

	always_comb begin
		quo_x = QW'(div_quo);
		if (quo_x < QW'(TEMPO_MIN)) tcand = TEMPO_MIN;
		else if (quo_x > QW'(TEMPO_MAX)) tcand = TEMPO_MAX;
		else tcand = quo_x[12:0];
		if (quo_x == '0) period = 32'd1;
		else if (quo_x > PERIOD_LIM) period = PERIOD_LIM[31:0];
		else period = quo_x[31:0];
	end

	// Config and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q        <= SR_RESET;
			pps_q       <= PPS_RESET;
			trig_q      <= 1'b1;
			tempo_q     <= TEMPO_RESET;
			measured_q  <= 1'b0;
			follow_q    <= 1'b0;
			pcount_q    <= '0;
			group_q     <= '0;
			samples_q   <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SAMPLE_RATE:     sr_q  <= cfg_data;
					CFG_PULSES_PER_STEP: pps_q <= cfg_data[7:0];
				endcase
			end
			if (cmd.prep) begin
				if (conn_q) begin
					follow_q <= 1'b1;
					phase_q  <= '0;
					trig_q   <= trig_nxt;
					if (!measured_q) tempo_q <= knob_cl;
					if (ext_step) begin
						measured_q <= 1'b1;
						samples_q  <= '0;
						group_q    <= group_q + 2'd1;
					end else begin
						samples_q <= cnt_inc;
					end
					if (edge_det && !need_mod)
						pcount_q <= (p1 == {1'b0, div8}) ? 8'd0 : p1[7:0];
				end else begin
					follow_q   <= 1'b0;
					measured_q <= 1'b0;
					samples_q  <= '0;
					pcount_q   <= '0;
					tempo_q    <= knob_cl;
				end
			end
			if (cmd.mod_take) pcount_q <= div_rem[7:0];
			if (cmd.finish) begin
				if (conn_q) begin
					if (upd_q) tempo_q <= tcand_q;
				end else begin
					phase_q <= ph_next;
					if (int_step) group_q <= group_q + 2'd1;
				end
			end
			// Output valid
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Work registers and output payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			level_q <= in_data.clock_level;
			conn_q  <= in_data.clock_connected;
			knob_q  <= in_data.knob_tempo;
		end
		if (cmd.prep) begin
			upd_q     <= ext_step && measured_q && in_window;
			step_q    <= ext_step;
			quarter_q <= ext_step && (group_q == 2'd0);
			mod_num_q <= p1;
			mod_den_q <= div8;
			ph_inc_q  <= {1'b0, phase_q} + PH_UNIT;
			if (conn_q) begin
				div_num_q <= num_ext;
				div_den_q <= cnt_inc;
			end else begin
				div_num_q <= num_int;
				div_den_q <= DW'(knob_cl);
			end
		end
		if (cmd.adj) begin
			tcand_q  <= tcand;
			period_q <= period;
		end
		if (cmd.finish) begin
			if (conn_q) begin
				out_q.step_edge     <= step_q;
				out_q.quarter_edge  <= quarter_q;
				out_q.external_mode <= 1'b1;
				out_q.tempo_now     <= upd_q ? tcand_q : tempo_q;
			end else begin
				out_q.step_edge     <= int_step;
				out_q.quarter_edge  <= int_step && (group_q == 2'd0);
				out_q.external_mode <= 1'b0;
				out_q.tempo_now     <= tempo_q;
			end
		end
	end

	assign status.need_mod = need_mod;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

FILE: rtl/ctt_ctrl.sv
// Sequencer: one sample at a time through decode, divide and commit
module ctt_ctrl import ctt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PREP  = 7'b0000010,
		S_MOD   = 7'b0000100,
		S_MWAIT = 7'b0001000,
		S_START = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = status.need_mod ? S_MOD : S_START;
			end
			// reduce the pulse count after the divider was lowered
			S_MOD: begin
				cmd.start   = 1'b1;
				cmd.sel_mod = 1'b1;
				state_d     = S_MWAIT;
			end
			S_MWAIT: begin
				if (status.div_done) begin
					cmd.mod_take = 1'b1;
					state_d      = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (status.div_done) begin
					cmd.adj = 1'b1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

FILE: rtl/ctt_checker.sv
`include "clock_tempo_tracker_defines.svh"

// Port-level checks for the tracker
module ctt_checker import ctt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);
	logic quarter_out;
	logic tempo_ok;
	logic out_wait;

	assign quarter_out = out_valid && out_data.quarter_edge;
	assign tempo_ok    = (out_data.tempo_now >= TEMPO_MIN) && (out_data.tempo_now <= TEMPO_MAX);
	assign out_wait    = out_valid && out_stall;

	// one sample in flight: an accepted beat closes the input
	`CTT_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second beat accepted")

	// a quarter mark only comes with a step
	`CTT_ASSERT_IMP(a_quarter_step, quarter_out, out_data.step_edge, "quarter without step")

	// reported tempo stays within 20..300 BPM
	`CTT_ASSERT_IMP(a_tempo_range, out_valid, tempo_ok, "tempo out of range")

	// a stalled result holds
	`CTT_ASSERT_NXT(a_out_hold, out_wait, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind clock_tempo_tracker ctt_checker u_ctt_checker (.*);

FILE: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ctt_pkg::*;

	localparam int CNT_W         = 24;
	localparam int FRAC_W        = 8;
	localparam int RAND_ITEMS    = 1900;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_PRINTS    = 100;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cfg_we    = 1'b0;
	cfg_index_t      cfg_index = CFG_SAMPLE_RATE;
	logic [SR_W-1:0] cfg_data  = '0;
	logic            in_valid  = 1'b0;
	logic            in_stall;
	in_t             in_data   = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	out_t            out_data;

	// Tempo tracker mirror: register copies, tracker state and the reports still due
	class tempo_check;
		logic [SR_W-1:0]  rate;
		logic [7:0]       pps;
		bit               trig_hi;
		logic [12:0]      tempo;
		bit               measured;
		bit               ext;
		logic [7:0]       pulses;
		logic [1:0]       grp;
		logic [CNT_W-1:0] since;
		logic [31:0]      phase;
		out_t             due[$];
		int               mismatches;

		function new();
			rate       = SR_RESET;
			pps        = PPS_RESET;
			trig_hi    = 1'b1;
			tempo      = TEMPO_RESET;
			measured   = 1'b0;
			ext        = 1'b0;
			pulses     = '0;
			grp        = '0;
			since      = '0;
			phase      = '0;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [SR_W-1:0] v);
			case (idx)
				CFG_SAMPLE_RATE: begin
					rate = v;
				end
				CFG_PULSES_PER_STEP: begin
					pps = v[7:0];
				end
			endcase
		endfunction

		function logic [12:0] bound_tempo(longint unsigned t);
			if (t < TEMPO_MIN) return TEMPO_MIN;
			if (t > TEMPO_MAX) return TEMPO_MAX;
			return t[12:0];
		endfunction

		// Advance the tracker by one accepted input beat and queue its report
		function void take_sample(in_t s);
			int              level;
			bit              rise;
			longint unsigned hz, span, unit, lim, period, ph, div, nxt;
			out_t            r;
			level = int'(s.clock_level);
			rise  = 1'b0;
			r     = '0;
			hz    = 64'(rate);
			unit  = 64'd1 << FRAC_W;
			if (since != {CNT_W{1'b1}}) since = since + 1'b1;
			if (s.clock_connected) begin
				ext   = 1'b1;
				phase = '0;
				if (!measured) tempo = bound_tempo(s.knob_tempo);
				// hysteresis: low at or under 100 mV, rising edge at 2 V or more
				if (trig_hi) begin
					if (level <= TRIG_LOW_MV) trig_hi = 1'b0;
				end else if (level >= TRIG_HIGH_MV) begin
					trig_hi = 1'b1;
					rise    = 1'b1;
				end
				if (rise) begin
					div = (pps == 8'd0) ? 64'd1 : 64'(pps);
					if (pulses == 8'd0) begin
						span          = 64'(since);
						r.step_edge   = 1'b1;
						// measure only from the second step on, inside 1 ms .. 10 s
						if (measured && span * 1000 > hz && span < 10 * hz)
							tempo = bound_tempo((3840 * hz) / span);
						measured       = 1'b1;
						since          = '0;
						r.quarter_edge = (grp == 2'd0);
						grp            = grp + 2'd1;
					end
					nxt    = 64'(pulses);
					nxt    = (nxt + 1) % div;
					pulses = nxt[7:0];
				end
			end else begin
				ext      = 1'b0;
				measured = 1'b0;
				since    = '0;
				pulses   = '0;
				tempo    = bound_tempo(s.knob_tempo);
				lim      = 64'h1_0000_0000 - unit;
				period   = (240 * hz * unit) / tempo;
				if (period < 1) period = 1;
				if (period > lim) period = lim;
				ph = phase + unit;
				if (ph >= period) begin
					ph = ph - period;
					// period under one sample: drop the leftover
					if (ph >= period) ph = 0;
					r.step_edge    = 1'b1;
					r.quarter_edge = (grp == 2'd0);
					grp            = grp + 2'd1;
				end
				phase = ph[31:0];
			end
			r.external_mode = ext;
			r.tempo_now     = tempo;
			due.push_back(r);
		endfunction

		task flag(string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
		endtask

		// Compare one output beat with the oldest report due
		task match_report(out_t got);
			out_t want;
			if (due.size() == 0) begin
				flag($sformatf("output beat %h with no report due", got));
				return;
			end
			want = due.pop_front();
			if (got.step_edge !== want.step_edge)
				flag($sformatf("step_edge %b, want %b", got.step_edge, want.step_edge));
			if (got.quarter_edge !== want.quarter_edge)
				flag($sformatf("quarter_edge %b, want %b", got.quarter_edge, want.quarter_edge));
			if (got.external_mode !== want.external_mode)
				flag($sformatf("external_mode %b, want %b", got.external_mode,
					want.external_mode));
			if (got.tempo_now !== want.tempo_now)
				flag($sformatf("tempo_now %0d, want %0d", got.tempo_now, want.tempo_now));
		endtask
	endclass

	tempo_check book;
	bit         tx_idle;
	bit         rx_idle;
	bit         rx_hold;
	int         fed;

	// external clock waveform state
	bit         hi_half;
	int         half_left;
	int         half_max;
	bit         noisy;

	clock_tempo_tracker #(
		.COUNT_WIDTH(CNT_W),
		.PHASE_FRACTION_BITS(FRAC_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Both registers, one per cycle
	task automatic apply_setting(logic [SR_W-1:0] hz, logic [7:0] ppq);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SAMPLE_RATE;
		cfg_data  <= hz;
		book.set_reg(CFG_SAMPLE_RATE, hz);
		@(negedge clk);
		cfg_index <= CFG_PULSES_PER_STEP;
		cfg_data  <= {{(SR_W-8){1'b0}}, ppq};
		book.set_reg(CFG_PULSES_PER_STEP, {{(SR_W-8){1'b0}}, ppq});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one sample beat, held until accepted
	task automatic send_sample(logic [14:0] lvl, bit conn, logic [12:0] knob);
		int  gap;
		in_t s;
		s.clock_level     = lvl;
		s.clock_connected = conn;
		s.knob_tempo      = knob;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (in_stall);
		book.take_sample(s);
		fed++;
	endtask

	// Stop sending until every report is in, then let the block go quiet
	task automatic drain(int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.due.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	function automatic logic [14:0] pick_level(bit up);
		int v;
		if (noisy && $urandom_range(0, 3) == 0) return 15'($urandom);
		if (up) begin
			case ($urandom_range(0, 5))
				0: v = 2000;
				1: v = 12000;
				2: v = 16383;
				3: v = $urandom_range(101, 1999);
				default: v = $urandom_range(2000, 12000);
			endcase
		end else begin
			case ($urandom_range(0, 5))
				0: v = 100;
				1: v = -12000;
				2: v = -16384;
				3: v = $urandom_range(101, 1999);
				default: v = int'($urandom_range(0, 12100)) - 12000;
			endcase
		end
		return v[14:0];
	endfunction

	function automatic logic [14:0] next_level();
		if (half_left == 0) begin
			hi_half   = !hi_half;
			half_left = $urandom_range(1, half_max);
		end
		half_left--;
		return pick_level(hi_half);
	endfunction

	function automatic logic [12:0] pick_knob();
		case ($urandom_range(0, 7))
			0: return 13'd0;
			1: return 13'h1FFF;
			2: return TEMPO_MIN - 13'd1;
			3: return TEMPO_MAX + 13'd1;
			4: return 13'($urandom);
			default: return 13'($urandom_range(1600, 4800));
		endcase
	endfunction

	// Mostly clean clock trains in cable segments, with mode flips and noisy stretches
	task automatic run_phase(int len, bit hold_here, bit pause_here);
		int          seg_left;
		bit          conn;
		logic [12:0] knob;
		seg_left = 0;
		conn     = 1'b1;
		knob     = TEMPO_RESET;
		for (int k = 0; k < len; k++) begin
			if (seg_left == 0) begin
				conn     = ($urandom_range(0, 9) < 7);
				seg_left = $urandom_range(5, 60);
				knob     = pick_knob();
				noisy    = ($urandom_range(0, 9) == 0);
			end
			seg_left--;
			if ($urandom_range(0, 19) == 0) knob = pick_knob();
			if (hold_here && k == 10) rx_hold = 1'b1;
			if (pause_here && k == len / 2) drain(0);
			send_sample(next_level(), conn, knob);
		end
	endtask

	// Output side: random stalls per beat, one long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end
			n = rx_idle ? $urandom_range(0, 8) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			book.match_report(out_data);
		end
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [SR_W-1:0] hz;
		logic [7:0]      ppq;
		int              ph_no;
		int              start;
		book      = new();
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		rx_hold   = 1'b0;
		fed       = 0;
		hi_half   = 1'b1;
		half_left = 0;
		half_max  = 4;
		noisy     = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Tiny sample rate: sub-sample step period and unclamped measured tempo
		apply_setting(18'd3, 8'd0);
		send_sample(15'd0, 1'b0, 13'd0);
		send_sample(15'd0, 1'b0, 13'h1FFF);
		send_sample(15'd0, 1'b0, TEMPO_MIN - 13'd1);
		send_sample(15'd0, 1'b0, TEMPO_MAX + 13'd1);
		// trigger starts high, so a high level gives no edge yet
		send_sample(15'd2000, 1'b1, 13'd4800);
		send_sample(15'd100, 1'b1, 13'd4800);
		send_sample(15'd1999, 1'b1, 13'd4800);
		send_sample(15'd2000, 1'b1, 13'd4800);
		send_sample(15'd101, 1'b1, 13'd320);
		send_sample(-15'sd12000, 1'b1, 13'd320);
		send_sample(15'd12000, 1'b1, 13'd320);
		send_sample(15'h4000, 1'b1, 13'd320);
		send_sample(15'h3FFF, 1'b1, 13'd320);
		// leaving the cable clears the measurement
		send_sample(15'd0, 1'b0, 13'd1920);

		// Zero rate never measures; run the divide-by-5 count up to 3
		drain(SETTLE_CYCLES);
		apply_setting(18'd0, 8'd5);
		repeat (3) begin
			send_sample(15'd0, 1'b1, 13'd2000);
			send_sample(15'd2000, 1'b1, 13'd2000);
		end

		// Divider shrunk below the running count: wraps first, steps on the next edge
		drain(SETTLE_CYCLES);
		apply_setting(18'd3, 8'd2);
		send_sample(15'd0, 1'b1, 13'd2000);
		send_sample(15'd2000, 1'b1, 13'd2000);
		send_sample(15'd0, 1'b1, 13'd2000);
		send_sample(15'd2000, 1'b1, 13'd2000);
		send_sample(15'd0, 1'b0, 13'd0);

		// Random phases, each with its own register setting
		ph_no = 0;
		start = fed;
		while (fed - start < RAND_ITEMS) begin
			drain(SETTLE_CYCLES);
			case (ph_no)
				0: begin
					hz  = 18'd1000;
					ppq = 8'd255;
				end
				1: begin
					hz  = 18'd192000;
					ppq = 8'd1;
				end
				2: begin
					hz  = '1;
					ppq = 8'd0;
				end
				3: begin
					hz  = 18'd0;
					ppq = 8'd2;
				end
				default: begin
					case ($urandom_range(0, 5))
						0: hz = SR_W'($urandom_range(0, 20));
						1, 2: hz = SR_W'($urandom_range(21, 300));
						3: hz = 18'd48000;
						default: hz = SR_W'($urandom_range(1000, 192000));
					endcase
					case ($urandom_range(0, 4))
						0: ppq = 8'($urandom);
						1: ppq = 8'd0;
						default: ppq = 8'($urandom_range(1, 4));
					endcase
				end
			endcase
			apply_setting(hz, ppq);
			half_max = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			tx_idle  = (ph_no != 2) && ($urandom_range(0, 3) != 0);
			rx_idle  = ($urandom_range(0, 3) != 0);
			run_phase($urandom_range(40, 160), ph_no == 2,
				ph_no == 3 || $urandom_range(0, 5) == 0);
			ph_no++;
		end

		drain(SETTLE_CYCLES);
		if (book.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/ctt_pkg.sv
rtl/ctt_div.sv
rtl/ctt_dpath.sv
rtl/ctt_ctrl.sv
rtl/clock_tempo_tracker.sv
rtl/ctt_checker.sv
verif/tb.sv
